@@ rtl/core/sacl_pkg.sv @@
package sacl_pkg;

  // access kinds carried on in_tuser
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  localparam int ADDR_W = 64;
  localparam int CNT_W  = 32;
  localparam int OFS_W  = 4;
  localparam logic [OFS_W-1:0] OFS_RESET = 4'd4;

  // outcome of one lookup, passed from the lookup logic to the control
  typedef struct packed {
    logic hit;
    logic evicted;
  } look_t;

endpackage

@@ rtl/core/sacl_ram.sv @@
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/sacl_lookup.sv @@
module sacl_lookup #(
  parameter int WAYS  = 4,
  parameter int TAG_W = 62,
  parameter int RW    = 2
) (
  input  logic [WAYS*(1+RW+TAG_W)-1:0] row_i,
  input  logic [TAG_W-1:0]             tag_i,
  output logic [WAYS*(1+RW+TAG_W)-1:0] row_o,
  output sacl_pkg::look_t              look_o
);

  localparam int EW = 1 + RW + TAG_W;
  localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0]  vld;
  logic [WAYS-1:0]  hitv;
  logic [WAYS-1:0]  invv;
  logic [WAYS-1:0]  lruv;
  logic [RW-1:0]    rnk [WAYS];
  logic [TAG_W-1:0] tg  [WAYS];
  logic [WI-1:0]    hit_idx;
  logic [WI-1:0]    inv_idx;
  logic [WI-1:0]    lru_idx;
  logic [WI-1:0]    tgt;
  logic             hit;
  logic             tgt_v;
  logic [RW-1:0]    tgt_r;

  // unpack the set row and flag each way
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      vld[w]  = row_i[w*EW + RW + TAG_W];
      rnk[w]  = row_i[w*EW + TAG_W +: RW];
      tg[w]   = row_i[w*EW +: TAG_W];
      hitv[w] = vld[w] && (tg[w] == tag_i);
      invv[w] = !vld[w];
      // a full set holds every rank once, so the oldest line has the top rank
      lruv[w] = (rnk[w] == RW'(WAYS - 1));
    end
  end

  // lowest way wins in each pick
  always_comb begin
    hit_idx = '0;
    inv_idx = '0;
    lru_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hitv[w]) begin
        hit_idx = WI'(w);
      end
      if (invv[w]) begin
        inv_idx = WI'(w);
      end
      if (lruv[w]) begin
        lru_idx = WI'(w);
      end
    end
  end

  assign hit = |hitv;
  assign tgt = hit ? hit_idx : ((|invv) ? inv_idx : lru_idx);
  assign tgt_v = vld[tgt];
  assign tgt_r = rnk[tgt];

  assign look_o.hit     = hit;
  assign look_o.evicted = !hit && !(|invv);

  // target becomes most recent; valid lines younger than it age by one
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (WI'(w) == tgt) begin
        row_o[w*EW +: EW] = {1'b1, {RW{1'b0}}, tag_i};
      end else if (vld[w] && (!tgt_v || (rnk[w] < tgt_r))) begin
        row_o[w*EW +: EW] = {vld[w], rnk[w] + RW'(1), tg[w]};
      end else begin
        row_o[w*EW +: EW] = {vld[w], rnk[w], tg[w]};
      end
    end
  end

endmodule

@@ rtl/core/set_assoc_cache_lru_sim_core.sv @@
// set-associative cache model with true lru replacement
// input channel in_*: one memory access per transfer, kind on in_tuser
// (0 load, 1 store, 2 modify, 3 acts as a load), byte address on in_tdata
// result channel out_*: one result per access with hit and eviction flags
// and the running 32-bit hit, miss and eviction totals (wrapping)
// cfg_wr_en/cfg_wr_data: writes offset_bits, the number of address bits
// dropped below the set index; write only while no access is in flight
// every set lives in one row of a synchronous ram: valid, age rank and tag
// of each way; an access reads its row, updates it and writes it back
// the ram row is read on the input transfer; the updated row and the result
// are registered on commit, once the result slot is free
// an access is taken only in the idle state, so the next one waits for the
// ram read and the write-back of the same row
// reset: ram rows are cleared one per cycle, all 2**SET_BITS of them, with
// in_tready low; offset_bits returns to 4 and the totals to zero
// a stalled result stays in the output register; the next access can be
// taken meanwhile, but its write-back waits until the result slot frees
module set_assoc_cache_lru_sim_core #(
  parameter int SET_BITS = 2,
  parameter int WAYS     = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_wr_en,
  input  logic [3:0]   cfg_wr_data,   // offset_bits
  // access input
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,      // address[63:0]
  input  logic [1:0]   in_tuser,      // op[1:0]
  // result output
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata      // hit, evicted, hits_total[31:0],
                                      // misses_total[31:0],
                                      // evictions_total[31:0], zero pad
);

  localparam int SETS  = 1 << SET_BITS;
  localparam int IDX_W = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W = sacl_pkg::ADDR_W - SET_BITS;
  localparam int RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = WAYS * (1 + RW + TAG_W);
  localparam int SH_W  = 6;

  // controller states
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [IDX_W-1:0]              clr_idx_r, clr_idx_nxt;
  logic [sacl_pkg::OFS_W-1:0]    ofs_r;
  logic [sacl_pkg::OP_W-1:0]     op_r;
  logic [IDX_W-1:0]              set_r;
  logic [TAG_W-1:0]              tag_r;
  logic [sacl_pkg::CNT_W-1:0]    hits_r, misses_r, evicts_r;
  logic [sacl_pkg::CNT_W-1:0]    hits_nxt, misses_nxt, evicts_nxt;
  logic                          out_tvalid_r;
  logic [103:0]                  out_tdata_r;

  logic                          in_xfer;
  logic                          slot_free;
  logic                          commit;
  logic [sacl_pkg::ADDR_W-1:0]   addr_set_sh;
  logic [SH_W-1:0]               tag_sh;
  logic [IDX_W-1:0]              in_set;
  logic [TAG_W-1:0]              in_tag;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [ROW_W-1:0]              ram_wdata;
  logic [ROW_W-1:0]              ram_rdata;
  logic [ROW_W-1:0]              row_upd;
  sacl_pkg::look_t               look;

  // split the address into set index and tag
  assign addr_set_sh = in_tdata >> ofs_r;
  assign tag_sh      = SH_W'(ofs_r) + SH_W'(SET_BITS);
  assign in_set      = IDX_W'(addr_set_sh) & IDX_W'(SETS - 1);
  assign in_tag      = TAG_W'(in_tdata >> tag_sh);

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;
  assign commit    = (state_r == S_LOOK) && slot_free;

  // row memory: one row per set; read on the input transfer, written on commit and while clearing
  assign ram_we    = (state_r == S_CLEAR) || commit;
  assign ram_waddr = (state_r == S_CLEAR) ? clr_idx_r : set_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : row_upd;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_xfer),
    .rd_addr (in_set),
    .rd_data (ram_rdata)
  );

  sacl_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .RW    (RW)
  ) u_lookup (
    .row_i  (ram_rdata),
    .tag_i  (tag_r),
    .row_o  (row_upd),
    .look_o (look)
  );

  // totals; the second half of a modify always hits
  always_comb begin
    hits_nxt   = hits_r + sacl_pkg::CNT_W'(look.hit)
               + sacl_pkg::CNT_W'(op_r == sacl_pkg::OP_MODIFY);
    misses_nxt = misses_r + sacl_pkg::CNT_W'(!look.hit);
    evicts_nxt = evicts_r + sacl_pkg::CNT_W'(look.evicted);
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_W'(SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      ofs_r        <= sacl_pkg::OFS_RESET;
      hits_r       <= '0;
      misses_r     <= '0;
      evicts_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (cfg_wr_en) begin
        ofs_r <= cfg_wr_data;
      end
      if (commit) begin
        hits_r       <= hits_nxt;
        misses_r     <= misses_nxt;
        evicts_r     <= evicts_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // access payload and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_tuser;
      set_r <= in_set;
      tag_r <= in_tag;
    end
    if (commit) begin
      out_tdata_r <= {6'd0, evicts_nxt, misses_nxt, hits_nxt, look.evicted, look.hit};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
